>>> hw/rtl/sim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sim_pkg
// Shared types and constants of the sorted interval merger.
// ----------------------------------------------------------------------------
package sim_pkg;

  localparam int MAX_INTERVALS_DEF = 64;
  localparam int IN_QUEUE_DEPTH    = 2;
  localparam int OUT_QUEUE_DEPTH   = 2;

  typedef struct packed {
    logic [7:0]  chrom_code;
    logic [30:0] region_start;
    logic [30:0] region_end;
    logic        has_prefix;
    logic        batch_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_chrom;
    logic [30:0] out_start;
    logic [30:0] out_end;
    logic        out_prefix;
    logic        out_last;
    logic        dropped_any;
  } out_beat_t;

  // One held interval.
  typedef struct packed {
    logic [7:0]  chrom;
    logic [30:0] start;
    logic [30:0] stop;
    logic        prefix;
  } cell_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } sort_state_t;

endpackage

>>> hw/rtl/sim_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sim_fifo
// Small synchronous queue used on both sides of the sorter.
// ----------------------------------------------------------------------------
module sim_fifo #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    cnt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/sim_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sim_sorter
// Insertion cell array with duplicate absorption, and the drain pass that walks the
// array in order at the end of a batch, merging runs when merge mode is on.
// ----------------------------------------------------------------------------
module sim_sorter #(
  parameter int MAX_INTERVALS = sim_pkg::MAX_INTERVALS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                merge_mode,
  input  sim_pkg::in_beat_t   in_beat,
  input  logic                in_valid,
  output logic                in_pop,
  output sim_pkg::out_beat_t  out_beat,
  output logic                out_push,
  input  logic                out_full
);

  localparam int CW = $clog2(MAX_INTERVALS + 1);

  sim_pkg::cell_t      cells [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] vld;
  logic [MAX_INTERVALS-1:0] gt;
  logic [MAX_INTERVALS-1:0] eq;
  logic [CW-1:0]       count;
  logic                overflow;
  sim_pkg::sort_state_t state;
  sim_pkg::sort_state_t state_next;
  sim_pkg::cell_t      new_cell;
  logic                dup;
  logic                ins_ok;
  logic                drain_step;
  logic                join_run;
  logic                run_vld;
  logic [7:0]          run_chrom;
  logic [30:0]         run_start;
  logic [30:0]         run_end;
  logic                run_prefix;

  assign new_cell = '{chrom: in_beat.chrom_code, start: in_beat.region_start,
                      stop: in_beat.region_end, prefix: in_beat.has_prefix};

  // Each cell compares its entry with the arriving interval. An empty cell
  // counts as larger, so the insertion point is the first larger cell.
  always_comb begin
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      gt[i] = !vld[i] || ({cells[i].chrom, cells[i].start, cells[i].stop} >
                          {new_cell.chrom, new_cell.start, new_cell.stop});
      eq[i] = vld[i] && ({cells[i].chrom, cells[i].start, cells[i].stop} ==
                         {new_cell.chrom, new_cell.start, new_cell.stop});
    end
  end

  assign dup    = |eq;
  assign ins_ok = !dup && (count < CW'(MAX_INTERVALS));

  always_comb begin
    state_next = state;
    unique case (state)
      sim_pkg::ST_LOAD: begin
        if (in_valid && in_beat.batch_last) begin
          state_next = sim_pkg::ST_DRAIN;
        end
      end
      sim_pkg::ST_DRAIN: begin
        if (!out_full && !vld[0]) begin
          state_next = sim_pkg::ST_LOAD;
        end
      end
      default: state_next = sim_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_pop     = (state == sim_pkg::ST_LOAD) && in_valid;
    drain_step = (state == sim_pkg::ST_DRAIN) && !out_full;
  end

  // The head cell joins the run when it is on the same chromosome and starts
  // no later than one past the running end.
  assign join_run = merge_mode && run_vld && (cells[0].chrom == run_chrom) &&
                    ({1'b0, cells[0].start} <= ({1'b0, run_end} + 32'd1));

  assign out_push = drain_step && ((vld[0] && run_vld && !join_run) || !vld[0]);

  always_comb begin
    out_beat.out_chrom   = run_chrom;
    out_beat.out_start   = run_start;
    out_beat.out_end     = run_end;
    out_beat.out_prefix  = run_prefix;
    out_beat.out_last    = !vld[0];
    out_beat.dropped_any = overflow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sim_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop && ins_ok) begin
      for (int i = 0; i < MAX_INTERVALS; i++) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cells[i] <= cells[(i > 0) ? i - 1 : 0];
        end else if (gt[i]) begin
          cells[i] <= new_cell;
        end
      end
    end else if (drain_step && vld[0]) begin
      for (int i = 0; i < MAX_INTERVALS - 1; i++) begin
        cells[i] <= cells[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      count    <= '0;
      overflow <= 1'b0;
    end else if (in_pop) begin
      if (ins_ok) begin
        for (int i = 0; i < MAX_INTERVALS; i++) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            vld[i] <= vld[(i > 0) ? i - 1 : 0];
          end else if (gt[i]) begin
            vld[i] <= 1'b1;
          end
        end
        count <= count + 1'b1;
      end else if (!dup) begin
        overflow <= 1'b1;
      end
    end else if (drain_step) begin
      if (vld[0]) begin
        vld <= {1'b0, vld[MAX_INTERVALS-1:1]};
      end else begin
        count    <= '0;
        overflow <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_vld <= 1'b0;
    end else if (drain_step) begin
      run_vld <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (drain_step && vld[0]) begin
      if (join_run) begin
        if (cells[0].stop > run_end) begin
          run_end <= cells[0].stop;
        end
      end else begin
        run_chrom  <= cells[0].chrom;
        run_start  <= cells[0].start;
        run_end    <= cells[0].stop;
        run_prefix <= cells[0].prefix;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_INTERVALS))
    else $error("held count above capacity");

  a_drain_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state == sim_pkg::ST_DRAIN) |-> !in_pop)
    else $error("input taken during drain");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (vld == '0))
    else $error("valid cell with zero count");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    (out_push && out_beat.out_last) |=> (state == sim_pkg::ST_LOAD))
    else $error("drain continued after final beat");
`endif

endmodule

>>> hw/rtl/sorted_interval_merger_core.sv
`timescale 1ns / 1ps
// A beat accepted into the input queue is inserted into the cell array when the sorter
// pops it in load state. After the last beat of a batch the drain loads the head cell
// into the run register, and a run enters the output queue only once it stops absorbing
// further intervals. Throughput: one item per cycle while loading; the drain steps through
// every held interval, and the sender stalls once two beats wait behind a drain.
// Reset (rst, synchronous): clears queues, state, valid bits, count and overflow.
// ----------------------------------------------------------------------------
// sorted_interval_merger_core
// Sorts, deduplicates and optionally merges a batch of genomic intervals.
// ----------------------------------------------------------------------------
module sorted_interval_merger_core #(
  parameter int MAX_INTERVALS = sim_pkg::MAX_INTERVALS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sim_pkg::in_beat_t  in_data,
  output logic               empty,
  input  logic               pop,
  output sim_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  // The front is the input queue: it takes beats whenever it has room, so
  // the sender stalls only while the back is draining a batch.
  sim_pkg::in_beat_t  q_beat;
  logic               q_empty;
  logic               q_pop;
  sim_pkg::out_beat_t s_beat;
  logic               s_push;
  logic               o_full;
  logic               merge_mode;

  // The one configuration register; it resets to 1. The user must write it only while
  // idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      merge_mode <= 1'b1;
    end else if (cfg_we) begin
      merge_mode <= cfg_wdata;
    end
  end

  sim_fifo #(
    .WIDTH ($bits(sim_pkg::in_beat_t)),
    .DEPTH (sim_pkg::IN_QUEUE_DEPTH)
  ) u_in_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (in_data),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_beat),
    .empty   (q_empty)
  );

  // The back sorts each beat into place and, after the last beat of a batch,
  // walks the array in order while building merged runs.
  sim_sorter #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_sorter (
    .clk        (clk),
    .rst        (rst),
    .merge_mode (merge_mode),
    .in_beat    (q_beat),
    .in_valid   (!q_empty),
    .in_pop     (q_pop),
    .out_beat   (s_beat),
    .out_push   (s_push),
    .out_full   (o_full)
  );

  // Result queue: finished runs wait here so the drain stalls only when the
  // consumer falls behind.
  sim_fifo #(
    .WIDTH ($bits(sim_pkg::out_beat_t)),
    .DEPTH (sim_pkg::OUT_QUEUE_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s_push),
    .wr_data (s_beat),
    .full    (o_full),
    .rd_en   (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

endmodule

>>> tb/tb_sorted_interval_merger_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_interval_merger_core
// Self-checking bench for the interval sorter and merger: batches of intervals
// are pushed with random bursts and gaps, a software sort/merge model predicts
// every output beat, and a checker pops results against those predictions.
// ----------------------------------------------------------------------------
module tb_sorted_interval_merger_core;

  localparam int CAP = sim_pkg::MAX_INTERVALS_DEF;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  sim_pkg::in_beat_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  sim_pkg::out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  // Model state: the held intervals, kept sorted, plus the overflow flag.
  sim_pkg::cell_t held_list[$];
  bit overflow_seen;
  bit merge_on;
  sim_pkg::out_beat_t expected_beats[$];
  int fail_count;
  int idle_cycles;
  bit hold_off;
  bit stall_enable;

  sorted_interval_merger_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Order of two intervals: chromosome, then start, then end.
  function automatic int order_of(sim_pkg::cell_t a, sim_pkg::cell_t b);
    if (a.chrom != b.chrom) return a.chrom < b.chrom ? -1 : 1;
    if (a.start != b.start) return a.start < b.start ? -1 : 1;
    if (a.stop != b.stop) return a.stop < b.stop ? -1 : 1;
    return 0;
  endfunction

  function automatic sim_pkg::out_beat_t make_beat(sim_pkg::cell_t c);
    sim_pkg::out_beat_t b;
    b.out_chrom = c.chrom;
    b.out_start = c.start;
    b.out_end = c.stop;
    b.out_prefix = c.prefix;
    b.out_last = 1'b0;
    b.dropped_any = overflow_seen;
    return b;
  endfunction

  // Add one beat at the tail of the expected queue.
  function automatic void append_expected(sim_pkg::out_beat_t b);
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  // Insert one interval into the sorted list and, on the last beat of a
  // batch, turn the list into the expected output beats.
  task automatic predict_batch_step(sim_pkg::in_beat_t item);
    sim_pkg::cell_t c;
    sim_pkg::cell_t run;
    int pos;
    int cmp;
    bit dup;
    c.chrom = item.chrom_code;
    c.start = item.region_start;
    c.stop = item.region_end;
    c.prefix = item.has_prefix;
    pos = 0;
    dup = 1'b0;
    while (pos < held_list.size()) begin
      cmp = order_of(held_list[pos], c);
      if (cmp == 0) dup = 1'b1;
      if (cmp >= 0) break;
      pos++;
    end
    if (!dup) begin
      if (held_list.size() < CAP) held_list.insert(pos, c);
      else overflow_seen = 1'b1;
    end
    if (!item.batch_last) return;
    if (merge_on) begin
      run = held_list[0];
      for (int i = 1; i < held_list.size(); i++) begin
        // The adjacency test is done one bit wider so that end + 1 cannot wrap.
        if (held_list[i].chrom == run.chrom &&
            {1'b0, held_list[i].start} <= {1'b0, run.stop} + 32'd1) begin
          if (held_list[i].stop > run.stop) run.stop = held_list[i].stop;
        end else begin
          append_expected(make_beat(run));
          run = held_list[i];
        end
      end
      append_expected(make_beat(run));
    end else begin
      foreach (held_list[i]) append_expected(make_beat(held_list[i]));
    end
    expected_beats[expected_beats.size() - 1].out_last = 1'b1;
    held_list.delete();
    overflow_seen = 1'b0;
  endtask

  // Offer one beat and hold it until the block takes it. Full only changes
  // at a rising edge, so it is looked at in the low phase before each edge.
  task automatic send_interval(sim_pkg::in_beat_t item);
    push <= 1'b1;
    in_data <= item;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    predict_batch_step(item);
    // A random gap ends the burst now and then.
    if ($urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic finish_burst();
    push <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected beat has been popped, then let the block settle.
  task automatic drain_outputs();
    push <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_merge_mode(bit mode);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    merge_on = mode;
    @(posedge clk);
  endtask

  function automatic sim_pkg::in_beat_t make_interval(logic [7:0] ch, logic [30:0] st,
                                                      logic [30:0] en, bit pre,
                                                      bit last);
    sim_pkg::in_beat_t b;
    b.chrom_code = ch;
    b.region_start = st;
    b.region_end = en;
    b.has_prefix = pre;
    b.batch_last = last;
    return b;
  endfunction

  // Pop side: stalls on its own pattern, or holds off completely when asked.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual %p", $time, out_data);
          fail_count++;
        end else begin
          if (out_data !== expected_beats[0]) begin
            $display("%0t: mismatch expected %p actual %p", $time,
                     expected_beats[0], out_data);
            fail_count++;
          end
          void'(expected_beats.pop_front());
        end
      end
      pop <= !hold_off && (!stall_enable || ($urandom_range(0, 3) != 0));
    end
  end

  // Watchdog: counts cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Extremes of every field, duplicates, a zero start, reversed intervals
  // and an adjacent pair, in merge mode.
  task automatic test_directed_merge();
    set_merge_mode(1'b1);
    send_interval(make_interval(8'd1, 31'd100, 31'd200, 1'b1, 1'b0));
    send_interval(make_interval(8'd1, 31'd201, 31'd300, 1'b0, 1'b0));
    send_interval(make_interval(8'd1, 31'd100, 31'd200, 1'b0, 1'b0));
    send_interval(make_interval(8'd1, 31'd0, 31'd5, 1'b1, 1'b0));
    send_interval(make_interval(8'd2, 31'd500, 31'd10, 1'b0, 1'b0));
    send_interval(make_interval(8'd2, 31'd12, 31'd20, 1'b1, 1'b0));
    send_interval(make_interval(8'd255, 31'h7fffffff, 31'h7fffffff, 1'b1, 1'b0));
    send_interval(make_interval(8'd255, 31'd0, 31'h7ffffffe, 1'b0, 1'b0));
    send_interval(make_interval(8'd0, 31'd0, 31'd0, 1'b0, 1'b1));
    finish_burst();
    drain_outputs();
    // Single-interval batch.
    send_interval(make_interval(8'd25, 31'h55555555, 31'h2aaaaaaa, 1'b1, 1'b1));
    finish_burst();
    drain_outputs();
  endtask

  // Duplicates and an adjacent pair with merging off: everything sorted, duplicates dropped.
  task automatic test_directed_sort_only();
    set_merge_mode(1'b0);
    send_interval(make_interval(8'd23, 31'd10, 31'd20, 1'b1, 1'b0));
    send_interval(make_interval(8'd23, 31'd21, 31'd30, 1'b0, 1'b0));
    send_interval(make_interval(8'd24, 31'd0, 31'd0, 1'b0, 1'b0));
    send_interval(make_interval(8'd23, 31'd10, 31'd20, 1'b0, 1'b0));
    send_interval(make_interval(8'd23, 31'd10, 31'd20, 1'b0, 1'b1));
    finish_burst();
    drain_outputs();
  endtask

  // More distinct intervals than the store holds, with the output held off
  // long enough that the block backs up into its input.
  task automatic test_overflow_and_backpressure();
    int n;
    set_merge_mode(1'b0);
    hold_off = 1'b1;
    n = CAP + 2;
    for (int i = 0; i < n; i++)
      send_interval(make_interval(8'($urandom_range(0, 3)), 31'($urandom),
                                  31'($urandom), 1'($urandom), i == n - 1));
    finish_burst();
    // Keep the output stalled for a long stretch before releasing it.
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
    drain_outputs();
    // Two batches pushed while the output is stalled: the second one backs
    // up behind the stalled drain of the first and stalls the input.
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 16; i++)
          send_interval(make_interval(8'(3 + i / 8), 31'((i % 8) * 4),
                                      31'((i % 8) * 4 + 1), 1'b1, (i % 8) == 7));
        finish_burst();
      end
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain_outputs();
  endtask

  // Random batches; mostly small coordinates on few chromosomes so that
  // overlaps, adjacency and duplicates happen often.
  task automatic test_random_batches();
    int sent;
    int len;
    logic [30:0] st;
    logic [30:0] en;
    sent = 0;
    while (sent < 12) begin
      set_merge_mode(1'($urandom_range(0, 3) != 0));
      stall_enable = 1'($urandom);
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          st = 31'($urandom);
          en = 31'($urandom);
        end else begin
          st = 31'($urandom_range(0, 60));
          en = st + 31'($urandom_range(0, 12));
          if ($urandom_range(0, 9) == 0) en = 31'($urandom_range(0, 60));
        end
        send_interval(make_interval(8'($urandom_range(0, 9) == 0 ? $urandom
                                        : $urandom_range(1, 3)),
                                    st, en, 1'($urandom), i == len - 1));
      end
      sent += len;
      finish_burst();
      drain_outputs();
    end
    set_merge_mode(1'b1);
  endtask

  initial begin
    fail_count = 0;
    hold_off = 1'b0;
    stall_enable = 1'b1;
    overflow_seen = 1'b0;
    merge_on = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_merge();
    test_directed_sort_only();
    test_overflow_and_backpressure();
    test_random_batches();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
